// ----- rtl/core/hbd_pkg.sv -----
// Shared types, constants and helper functions for the H-bridge drive block.
// Used by hbd_poly_cell, hbd_lane, hbd_mix and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hbd_pkg;

  // Angle resolution and duty ceiling of the bridge.
  localparam int AngleBits = 16;
  localparam int DutyMax   = 255;
  localparam int LowBits   = (AngleBits < 16) ? (16 - AngleBits) : 0;
  localparam logic [15:0] AngleMask = 16'hFFFF << LowBits;

  // Odd polynomial coefficients of the quarter-wave sine, Q16.
  localparam int SinA = 102944;
  localparam int SinB = 42048;
  localparam int SinC = 4640;

  localparam logic [7:0] TurnGainRst = 8'd32;

  // Rounding bias for a 2^-28 value, half away from zero.
  localparam logic signed [44:0] RoundPos = 45'sh0000_8000_000;
  localparam logic signed [44:0] RoundNeg = 45'sh0000_7FFF_FFF;

  typedef enum logic [1:0] {
    OP_DIRECT = 2'd0,
    OP_VECTOR = 2'd1,
    OP_BRAKE  = 2'd2
  } op_t;

  // One lane of the sine polynomial as it moves down the cell row.
  typedef struct packed {
    logic [16:0] t;
    logic [16:0] t2;
    logic [16:0] acc;
    logic        neg;
  } lane_t;

  // Command fields that ride alongside the lanes.
  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [15:0]        mag;
  } side_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       rev;
  } drive_t;

  // Clamp a signed speed and map it onto duty plus direction.
  function automatic drive_t to_drive(input logic signed [16:0] v);
    logic signed [16:0] dm;
    logic signed [16:0] lim;
    logic signed [16:0] rdu;
    drive_t             d;
    dm = 17'(DutyMax);
    if (v > dm) begin
      lim = dm;
    end else if (v < -dm) begin
      lim = -dm;
    end else begin
      lim = v;
    end
    rdu = dm + lim;
    if (lim > 17'sd0) begin
      d.duty = lim[7:0];
      d.rev  = 1'b0;
    end else if (lim < 17'sd0) begin
      d.duty = rdu[7:0];
      d.rev  = 1'b1;
    end else begin
      d.duty = 8'd0;
      d.rev  = 1'b0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hbd_cmd_if.sv -----
// Command channel: valid/ready handshake with the drive command fields.
// Depends on nothing but the clock of the enclosing design.
`timescale 1ns / 1ps
`default_nettype none

interface hbd_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic [15:0]        magnitude;
  logic [15:0]        heading;

  modport source (
    output valid, operation, left_speed, right_speed, magnitude, heading,
    input  ready
  );
  modport sink (
    input  valid, operation, left_speed, right_speed, magnitude, heading,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/hbd_drv_if.sv -----
// Drive result channel: valid/ready handshake with duties and direction flags.
// Depends on nothing but the clock of the enclosing design.
`timescale 1ns / 1ps
`default_nettype none

interface hbd_drv_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_duty;
  logic       left_reverse;
  logic [7:0] right_duty;
  logic       right_reverse;
  logic       brake;

  modport source (
    output valid, left_duty, left_reverse, right_duty, right_reverse, brake,
    input  ready
  );
  modport sink (
    input  valid, left_duty, left_reverse, right_duty, right_reverse, brake,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/hbd_poly_cell.sv -----
// One sine polynomial row cell: a 17x17 multiply and shift, then an optional subtract or load.
// Depends on hbd_pkg for the lane type and coefficients.
`timescale 1ns / 1ps
`default_nettype none

module hbd_poly_cell #(
  parameter bit MUL_T2 = 1'b0,
  parameter bit FIRST  = 1'b0,
  parameter bit SUB    = 1'b0,
  parameter int K_ADD  = 0
) (
  input  logic          clk,
  input  logic          en,
  input  hbd_pkg::lane_t lane_in,
  output hbd_pkg::lane_t lane_out
);

  logic [16:0]    mul;
  logic [33:0]    prod;
  logic [16:0]    scaled;
  hbd_pkg::lane_t lane_nxt;
  hbd_pkg::lane_t lane_r;

  assign mul    = MUL_T2 ? lane_in.t2 : lane_in.t;
  assign prod   = {17'd0, mul} * {17'd0, lane_in.acc};
  // All terms stay within 17 bits after the Q16 shift.
  assign scaled = prod[32:16];

  always_comb begin
    lane_nxt = lane_in;
    if (FIRST) begin
      // square of t, then load the innermost coefficient
      lane_nxt.t2  = scaled;
      lane_nxt.acc = 17'(hbd_pkg::SinC);
    end else if (SUB) begin
      lane_nxt.acc = 17'(K_ADD) - scaled;
    end else begin
      lane_nxt.acc = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_out = lane_r;

endmodule

`default_nettype wire

// ----- rtl/core/hbd_lane.sv -----
// Row of four polynomial cells that turns a quadrant-folded angle into a sine.
// Depends on hbd_pkg and hbd_poly_cell.
`timescale 1ns / 1ps
`default_nettype none

module hbd_lane (
  input  logic           clk,
  input  logic           en,
  input  hbd_pkg::lane_t lane_in,
  output hbd_pkg::lane_t lane_out
);

  hbd_pkg::lane_t c0_out;
  hbd_pkg::lane_t c1_out;
  hbd_pkg::lane_t c2_out;

  // t2 = t*t
  hbd_poly_cell #(.MUL_T2(1'b0), .FIRST(1'b1), .SUB(1'b0), .K_ADD(0)) u_c0 (
    .clk(clk), .en(en), .lane_in(lane_in), .lane_out(c0_out)
  );
  // inner = B - t2*C
  hbd_poly_cell #(.MUL_T2(1'b1), .FIRST(1'b0), .SUB(1'b1), .K_ADD(hbd_pkg::SinB)) u_c1 (
    .clk(clk), .en(en), .lane_in(c0_out), .lane_out(c1_out)
  );
  // mid = A - t2*inner
  hbd_poly_cell #(.MUL_T2(1'b1), .FIRST(1'b0), .SUB(1'b1), .K_ADD(hbd_pkg::SinA)) u_c2 (
    .clk(clk), .en(en), .lane_in(c1_out), .lane_out(c2_out)
  );
  // y = t*mid
  hbd_poly_cell #(.MUL_T2(1'b0), .FIRST(1'b0), .SUB(1'b0), .K_ADD(0)) u_c3 (
    .clk(clk), .en(en), .lane_in(c2_out), .lane_out(lane_out)
  );

endmodule

`default_nettype wire

// ----- rtl/core/hbd_mix.sv -----
// Four-stage mixer: scales sine and cosine by magnitude and gain, forms the
// wheel sums and rounds them, or passes the direct speeds through. Depends on hbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbd_mix (
  input  logic                      clk,
  input  logic                      en,
  input  logic [7:0]                turn_gain,
  input  hbd_pkg::side_t            side_in,
  input  hbd_pkg::lane_t            sin_in,
  input  hbd_pkg::lane_t            cos_in,
  output hbd_pkg::side_t            side_out,
  output logic signed [16:0]        left_v,
  output logic signed [16:0]        right_v
);

  hbd_pkg::side_t side_r [4];

  logic signed [17:0] sin_s;
  logic signed [17:0] cos_s;
  logic signed [34:0] fwd1_r;
  logic signed [34:0] trn1_r;
  logic signed [44:0] fwd2_r;
  logic signed [44:0] trn2_r;
  logic signed [44:0] left3_r;
  logic signed [44:0] right3_r;
  logic signed [44:0] left_rnd;
  logic signed [44:0] right_rnd;
  logic signed [16:0] left4_r;
  logic signed [16:0] right4_r;
  logic signed [16:0] left4_nxt;
  logic signed [16:0] right4_nxt;

  assign sin_s = sin_in.neg ? -$signed({1'b0, sin_in.acc}) : $signed({1'b0, sin_in.acc});
  assign cos_s = cos_in.neg ? -$signed({1'b0, cos_in.acc}) : $signed({1'b0, cos_in.acc});

  assign left_rnd  = left3_r + (left3_r[44] ? hbd_pkg::RoundNeg : hbd_pkg::RoundPos);
  assign right_rnd = right3_r + (right3_r[44] ? hbd_pkg::RoundNeg : hbd_pkg::RoundPos);

  always_comb begin
    if (side_r[2].op == hbd_pkg::OP_VECTOR) begin
      left4_nxt  = left_rnd[44:28];
      right4_nxt = right_rnd[44:28];
    end else begin
      left4_nxt  = 17'(side_r[2].left_speed);
      right4_nxt = 17'(side_r[2].right_speed);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];
      side_r[3] <= side_r[2];
      fwd1_r    <= 35'($signed({1'b0, side_in.mag})) * 35'(cos_s);
      trn1_r    <= 35'($signed({1'b0, side_in.mag})) * 35'(sin_s);
      fwd2_r    <= 45'(fwd1_r) <<< 4;
      trn2_r    <= 45'(trn1_r) * 45'($signed({1'b0, turn_gain}));
      left3_r   <= fwd2_r - trn2_r;
      right3_r  <= fwd2_r + trn2_r;
      left4_r   <= left4_nxt;
      right4_r  <= right4_nxt;
    end
  end

  assign side_out = side_r[3];
  assign left_v   = left4_r;
  assign right_v  = right4_r;

endmodule

`default_nettype wire

// ----- rtl/core/vector_to_hbridge_drive_top.sv -----
// Top level of the two-motor H-bridge drive block.
// Depends on hbd_pkg, hbd_cmd_if, hbd_drv_if, hbd_lane and hbd_mix.
`timescale 1ns / 1ps
`default_nettype none

// Turns one drive command into duty and direction for two H-bridge motors:
// direct signed speeds, a vector of magnitude and heading mixed with
// turn_gain (Q4.4, reset 2.0), a brake, or a stop. The block takes one transaction
// per clock while the row does not stall; its result passes through one input
// register, a row of four polynomial cells for sine and cosine, four mixing
// stages (magnitude multiply, gain multiply, wheel sums, rounding) and an
// output register. The row stalls only when a finished result sits in the
// output register unclaimed and another one arrives behind it. Write
// turn_gain only while no transaction is in flight.
module vector_to_hbridge_drive_top (
  input  logic            clk,
  input  logic            rst_n,
  hbd_cmd_if.sink         in_ch,
  hbd_drv_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata
);

  localparam int NumStages = 9;

  logic                 adv;
  logic                 in_fire;
  logic [NumStages-1:0] vld_r;
  logic [7:0]           turn_gain_r;

  logic [15:0]          phase;
  logic [15:0]          cos_phase;
  hbd_pkg::lane_t       sin_init;
  hbd_pkg::lane_t       cos_init;
  hbd_pkg::lane_t       sin_init_r;
  hbd_pkg::lane_t       cos_init_r;
  hbd_pkg::lane_t       sin_out;
  hbd_pkg::lane_t       cos_out;
  hbd_pkg::side_t       side_in;
  hbd_pkg::side_t       side_r [5];
  hbd_pkg::side_t       mix_side;
  logic signed [16:0]   left_v;
  logic signed [16:0]   right_v;

  hbd_pkg::drive_t      left_drv;
  hbd_pkg::drive_t      right_drv;
  logic                 out_valid_r;
  logic [7:0]           left_duty_r, left_duty_nxt;
  logic                 left_rev_r, left_rev_nxt;
  logic [7:0]           right_duty_r, right_duty_nxt;
  logic                 right_rev_r, right_rev_nxt;
  logic                 brake_r, brake_nxt;

  // Advance unless a finished transaction would overrun a held output.
  assign adv     = !vld_r[NumStages-1] || !out_valid_r || out_ch.ready;
  assign in_fire = in_ch.valid && adv;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_gain_r <= hbd_pkg::TurnGainRst;
    end else if (cfg_we) begin
      turn_gain_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NumStages-2:0], in_fire};
    end
  end

  // Fold the angle into the first quadrant; the lower half turn negates.
  assign phase     = in_ch.heading & hbd_pkg::AngleMask;
  assign cos_phase = phase + 16'h4000;

  always_comb begin
    logic [14:0] r_sin;
    logic [14:0] r_cos;
    r_sin = {1'b0, phase[13:0]};
    r_cos = {1'b0, cos_phase[13:0]};
    if (phase[14]) begin
      r_sin = 15'd16384 - r_sin;
    end
    if (cos_phase[14]) begin
      r_cos = 15'd16384 - r_cos;
    end
    sin_init.t   = {r_sin, 2'b00};
    sin_init.t2  = '0;
    sin_init.acc = {r_sin, 2'b00};
    sin_init.neg = phase[15];
    cos_init.t   = {r_cos, 2'b00};
    cos_init.t2  = '0;
    cos_init.acc = {r_cos, 2'b00};
    cos_init.neg = cos_phase[15];
  end

  assign side_in.op          = in_ch.operation;
  assign side_in.left_speed  = in_ch.left_speed;
  assign side_in.right_speed = in_ch.right_speed;
  assign side_in.mag         = in_ch.magnitude;

  always_ff @(posedge clk) begin
    if (adv) begin
      sin_init_r <= sin_init;
      cos_init_r <= cos_init;
      side_r[0]  <= side_in;
      side_r[1]  <= side_r[0];
      side_r[2]  <= side_r[1];
      side_r[3]  <= side_r[2];
      side_r[4]  <= side_r[3];
    end
  end

  hbd_lane u_sin (
    .clk(clk), .en(adv), .lane_in(sin_init_r), .lane_out(sin_out)
  );

  hbd_lane u_cos (
    .clk(clk), .en(adv), .lane_in(cos_init_r), .lane_out(cos_out)
  );

  hbd_mix u_mix (
    .clk(clk),
    .en(adv),
    .turn_gain(turn_gain_r),
    .side_in(side_r[4]),
    .sin_in(sin_out),
    .cos_in(cos_out),
    .side_out(mix_side),
    .left_v(left_v),
    .right_v(right_v)
  );

  assign left_drv  = hbd_pkg::to_drive(left_v);
  assign right_drv = hbd_pkg::to_drive(right_v);

  always_comb begin
    left_duty_nxt  = 8'd0;
    left_rev_nxt   = 1'b0;
    right_duty_nxt = 8'd0;
    right_rev_nxt  = 1'b0;
    brake_nxt      = 1'b0;
    unique case (mix_side.op)
      hbd_pkg::OP_DIRECT, hbd_pkg::OP_VECTOR: begin
        left_duty_nxt  = left_drv.duty;
        left_rev_nxt   = left_drv.rev;
        right_duty_nxt = right_drv.duty;
        right_rev_nxt  = right_drv.rev;
      end
      hbd_pkg::OP_BRAKE: begin
        left_duty_nxt  = 8'(hbd_pkg::DutyMax);
        left_rev_nxt   = 1'b1;
        right_duty_nxt = 8'(hbd_pkg::DutyMax);
        right_rev_nxt  = 1'b1;
        brake_nxt      = 1'b1;
      end
      default: begin
        // all stop: every field stays low
        brake_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && vld_r[NumStages-1]) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_r[NumStages-1]) begin
      left_duty_r  <= left_duty_nxt;
      left_rev_r   <= left_rev_nxt;
      right_duty_r <= right_duty_nxt;
      right_rev_r  <= right_rev_nxt;
      brake_r      <= brake_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.left_duty     = left_duty_r;
  assign out_ch.left_reverse  = left_rev_r;
  assign out_ch.right_duty    = right_duty_r;
  assign out_ch.right_reverse = right_rev_r;
  assign out_ch.brake         = brake_r;

endmodule

`default_nettype wire

// ----- rtl/core/hbd_checker.sv -----
// Port-level checks for the H-bridge drive block, bound to its top level.
// Depends on vector_to_hbridge_drive_top and its channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module hbd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] left_duty,
  input wire logic       left_reverse,
  input wire logic [7:0] right_duty,
  input wire logic       right_reverse,
  input wire logic       brake
);

  // A held result keeps its fields until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_duty) && $stable(right_duty)
      && $stable(left_reverse) && $stable(right_reverse) && $stable(brake))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // An empty output register never back-pressures the command side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("command stalled with empty output");

  // Brake drives both bridges identically in reverse.
  a_brake_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && brake |-> left_reverse && right_reverse && left_duty == right_duty)
    else $error("brake result malformed");

endmodule

bind vector_to_hbridge_drive_top hbd_checker u_hbd_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .left_duty(out_ch.left_duty),
  .left_reverse(out_ch.left_reverse),
  .right_duty(out_ch.right_duty),
  .right_reverse(out_ch.right_reverse),
  .brake(out_ch.brake)
);

`default_nettype wire

// ----- tb/tb_vector_to_hbridge_drive_top.sv -----
// Self-checking testbench for vector_to_hbridge_drive_top: direct, vector, brake and stop
// commands, bursty sender and patterned receiver stalls, several turn_gain settings.
// Depends on hbd_pkg, hbd_cmd_if, hbd_drv_if and the block's RTL.
`timescale 1ns / 1ps

module tb_vector_to_hbridge_drive_top;
  import hbd_pkg::*;

  // Code 3 is unused by the block and stops both motors.
  localparam logic [1:0] OpStop = 2'd3;

  localparam logic [63:0] PolyA = 64'd102944;
  localparam logic [63:0] PolyB = 64'd42048;
  localparam logic [63:0] PolyC = 64'd4640;
  localparam logic [15:0] HeadingMask =
    (AngleBits < 16) ? (16'hFFFF << (16 - AngleBits)) : 16'hFFFF;

  localparam int unsigned CycleLimit = 400_000;
  localparam int          ItemsPerPhase = 232;
  localparam int          DrainCycles = 16;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [15:0]        magnitude;
    logic [15:0]        heading;
  } cmd_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       rev;
  } wheel_t;

  typedef struct packed {
    logic [7:0] left_duty;
    logic       left_reverse;
    logic [7:0] right_duty;
    logic       right_reverse;
    logic       brake;
  } bridge_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  hbd_cmd_if cmd_if ();
  hbd_drv_if drv_if ();

  vector_to_hbridge_drive_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (cmd_if),
    .out_ch    (drv_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cmd_t        cmd_q[$];
  bridge_t     bridge_q[$];
  cmd_t        held_cmd;
  bridge_t     want_drive;
  logic [7:0]  gain_model = TurnGainRst;
  logic [15:0] stall_pattern;
  int          burst_left;
  int          gap_left;
  int unsigned cycle_count = 0;
  int          error_count = 0;
  int          results_checked = 0;
  int          gain_settings = 1;
  int          op_seen[4] = '{0, 0, 0, 0};

  // Quarter-wave polynomial sine, Q16, mirrored and negated by quadrant.
  function automatic longint sine_q16(input logic [15:0] phase);
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] inner;
    logic [63:0] mid;
    logic [63:0] y;
    r = {50'd0, phase[13:0]};
    if (phase[14]) begin
      r = 64'd16384 - r;
    end
    t     = r << 2;
    t2    = (t * t) >> 16;
    inner = PolyB - ((t2 * PolyC) >> 16);
    mid   = PolyA - ((t2 * inner) >> 16);
    y     = (t * mid) >> 16;
    return phase[15] ? -longint'(y) : longint'(y);
  endfunction

  // Value in 2^-28 units to an integer, half away from zero.
  function automatic longint round_q28(input longint v);
    longint unsigned a;
    longint          q;
    a = (v < 0) ? longint'(-v) : longint'(v);
    q = longint'((a + (64'd1 << 27)) >> 28);
    return (v < 0) ? -q : q;
  endfunction

  function automatic wheel_t wheel_drive(input longint v);
    longint s;
    wheel_t w;
    s = v;
    if (s > DutyMax) s = DutyMax;
    if (s < -DutyMax) s = -DutyMax;
    if (s > 0) begin
      w.duty = 8'(s);
      w.rev  = 1'b0;
    end else if (s < 0) begin
      w.duty = 8'(DutyMax + s);
      w.rev  = 1'b1;
    end else begin
      w.duty = 8'd0;
      w.rev  = 1'b0;
    end
    return w;
  endfunction

  function automatic bridge_t mix_to_bridge(input cmd_t c, input logic [7:0] gain);
    bridge_t     res;
    logic [15:0] p;
    longint      cosv;
    longint      sinv;
    longint      mag;
    longint      fwd;
    longint      trn;
    res = '0;
    case (c.operation)
      OP_DIRECT: begin
        {res.left_duty, res.left_reverse}   = wheel_drive(longint'(c.left_speed));
        {res.right_duty, res.right_reverse} = wheel_drive(longint'(c.right_speed));
      end
      OP_VECTOR: begin
        p    = c.heading & HeadingMask;
        cosv = sine_q16(p + 16'd16384);
        sinv = sine_q16(p);
        mag  = longint'(c.magnitude);
        fwd  = mag * cosv * 16;
        trn  = mag * sinv * longint'(gain);
        {res.left_duty, res.left_reverse}   = wheel_drive(round_q28(fwd - trn));
        {res.right_duty, res.right_reverse} = wheel_drive(round_q28(fwd + trn));
      end
      OP_BRAKE: begin
        res.left_duty     = 8'(DutyMax);
        res.right_duty    = 8'(DutyMax);
        res.left_reverse  = 1'b1;
        res.right_reverse = 1'b1;
        res.brake         = 1'b1;
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic cmd_t make_cmd(input logic [1:0] op, input int ls, input int rs,
                                    input int mag, input int hd);
    cmd_t c;
    c.operation   = op;
    c.left_speed  = 16'(ls);
    c.right_speed = 16'(rs);
    c.magnitude   = 16'(mag);
    c.heading     = 16'(hd);
    return c;
  endfunction

  function automatic int rand_speed();
    case ($urandom_range(0, 3))
      0:       return int'($urandom_range(0, 600)) - 300;
      1:       return int'($urandom_range(0, 40)) - 20;
      default: return int'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   pick;
    c.left_speed  = 16'($urandom);
    c.right_speed = 16'($urandom);
    c.magnitude   = 16'($urandom);
    c.heading     = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      c.operation   = OP_DIRECT;
      c.left_speed  = 16'(rand_speed());
      c.right_speed = 16'(rand_speed());
    end else if (pick < 80) begin
      c.operation = OP_VECTOR;
      case ($urandom_range(0, 3))
        0: c.magnitude = 16'($urandom_range(0, 16'h0400));
        1: c.magnitude = 16'($urandom_range(0, 16'h3FFF));
        2: c.magnitude = 16'($urandom_range(0, 16'hFFFF));
        default: c.magnitude = 16'($urandom_range(16'hF000, 16'hFFFF));
      endcase
      // Land near a quadrant boundary now and then.
      if ($urandom_range(0, 4) == 0) begin
        c.heading = {2'($urandom_range(0, 3)), 14'd0} + 16'($urandom_range(0, 4)) - 16'd2;
      end
    end else if (pick < 90) begin
      c.operation = OP_BRAKE;
    end else begin
      c.operation = OpStop;
    end
    return c;
  endfunction

  task automatic wait_idle();
    while (cmd_q.size() != 0 || cmd_if.valid || bridge_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_turn_gain(input logic [7:0] g);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we     <= 1'b0;
    gain_model  = g;
    gain_settings++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    logic [7:0] phase_gain[7];
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = 8'd0;
    cmd_if.valid       = 1'b0;
    cmd_if.operation   = OP_DIRECT;
    cmd_if.left_speed  = '0;
    cmd_if.right_speed = '0;
    cmd_if.magnitude   = '0;
    cmd_if.heading     = '0;
    drv_if.ready       = 1'b0;
    phase_gain = '{8'd0, 8'd255, 8'd1, 8'd16, 8'($urandom), 8'($urandom), TurnGainRst};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed commands at the reset gain.
    cmd_q.push_back(make_cmd(OP_DIRECT, 0, 0, 16'h1234, 16'h4321));
    cmd_q.push_back(make_cmd(OP_DIRECT, 255, -255, 0, 0));
    cmd_q.push_back(make_cmd(OP_DIRECT, 256, -256, 16'hFFFF, 16'hFFFF));
    cmd_q.push_back(make_cmd(OP_DIRECT, 32767, -32768, 0, 0));
    cmd_q.push_back(make_cmd(OP_DIRECT, -32768, 32767, 16'hFFFF, 16'hFFFF));
    cmd_q.push_back(make_cmd(OP_DIRECT, 1, -1, 0, 0));
    cmd_q.push_back(make_cmd(OP_DIRECT, -1, 1, 0, 0));
    cmd_q.push_back(make_cmd(OP_BRAKE, -1, 12345, 16'hA5A5, 16'h5A5A));
    cmd_q.push_back(make_cmd(OpStop, 200, -200, 16'h8000, 16'h4000));
    cmd_q.push_back(make_cmd(OP_VECTOR, 100, -100, 0, 0));
    cmd_q.push_back(make_cmd(OP_VECTOR, 0, 0, 16'hFFFF, 0));
    cmd_q.push_back(make_cmd(OP_VECTOR, 0, 0, 16'hFFFF, 16'h4000));
    cmd_q.push_back(make_cmd(OP_VECTOR, 0, 0, 16'hFFFF, 16'h8000));
    cmd_q.push_back(make_cmd(OP_VECTOR, 0, 0, 16'hFFFF, 16'hC000));
    cmd_q.push_back(make_cmd(OP_VECTOR, 0, 0, 16'h0100, 16'hFFFF));
    // Exactly half a duty step forward and backward.
    cmd_q.push_back(make_cmd(OP_VECTOR, 0, 0, 16'h0080, 0));
    cmd_q.push_back(make_cmd(OP_VECTOR, 0, 0, 16'h0080, 16'h8000));
    cmd_q.push_back(make_cmd(OP_VECTOR, 0, 0, 16'h0100, 16'h2000));
    cmd_q.push_back(make_cmd(OP_VECTOR, 0, 0, 16'h1000, 16'hE000));
    repeat (ItemsPerPhase) cmd_q.push_back(rand_cmd());
    wait_idle();

    foreach (phase_gain[i]) begin
      write_turn_gain(phase_gain[i]);
      repeat (ItemsPerPhase) cmd_q.push_back(rand_cmd());
      wait_idle();
    end

    $display("covered %0d commands: %0d direct, %0d vector, %0d brake, %0d stop",
             op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("checked %0d drive results across %0d turn_gain settings",
             results_checked, gain_settings);
    if (error_count == 0) begin
      $display("tb_vector_to_hbridge_drive_top: done, clean");
    end else begin
      $display("tb_vector_to_hbridge_drive_top: done, errors");
    end
    $finish;
  end

  // Command driver: bursts of random length, random gaps between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_if.valid <= 1'b0;
      burst_left    = 0;
      gap_left      = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        bridge_q.push_back(mix_to_bridge(held_cmd, gain_model));
        op_seen[held_cmd.operation]++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (gap_left > 0 || cmd_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          cmd_if.valid <= 1'b0;
        end else begin
          held_cmd = cmd_q.pop_front();
          cmd_if.valid       <= 1'b1;
          cmd_if.operation   <= held_cmd.operation;
          cmd_if.left_speed  <= held_cmd.left_speed;
          cmd_if.right_speed <= held_cmd.right_speed;
          cmd_if.magnitude   <= held_cmd.magnitude;
          cmd_if.heading     <= held_cmd.heading;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
          end
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(1, 7);
        end
      end
    end
  end

  // Receiver: ready steps through a 16-bit pattern, redrawn when cycle_count[7:0] is zero.
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_if.ready  <= 1'b0;
      stall_pattern  = 16'hFFFF;
    end else begin
      if (cycle_count[7:0] == 8'd0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern = 16'hFFFF;
          1:       stall_pattern = 16'($urandom) | 16'h0001;
          2:       stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
          default: stall_pattern = 16'h00FF;
        endcase
      end
      drv_if.ready <= stall_pattern[cycle_count[3:0]];
    end
  end

  always @(posedge clk) begin
    if (rst_n && drv_if.valid && drv_if.ready) begin
      if (bridge_q.size() == 0) begin
        $error("drive result with no command pending");
        error_count++;
      end else begin
        want_drive = bridge_q.pop_front();
        results_checked++;
        if (drv_if.left_duty !== want_drive.left_duty) begin
          $error("left_duty: expected %0d, got %0d", want_drive.left_duty, drv_if.left_duty);
          error_count++;
        end
        if (drv_if.left_reverse !== want_drive.left_reverse) begin
          $error("left_reverse: expected %0d, got %0d",
                 want_drive.left_reverse, drv_if.left_reverse);
          error_count++;
        end
        if (drv_if.right_duty !== want_drive.right_duty) begin
          $error("right_duty: expected %0d, got %0d", want_drive.right_duty, drv_if.right_duty);
          error_count++;
        end
        if (drv_if.right_reverse !== want_drive.right_reverse) begin
          $error("right_reverse: expected %0d, got %0d",
                 want_drive.right_reverse, drv_if.right_reverse);
          error_count++;
        end
        if (drv_if.brake !== want_drive.brake) begin
          $error("brake: expected %0d, got %0d", want_drive.brake, drv_if.brake);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $error("timeout after %0d cycles, %0d results still pending", cycle_count,
             bridge_q.size());
      $display("tb_vector_to_hbridge_drive_top: done, errors");
      $finish;
    end
  end

endmodule

// ----- vector_to_hbridge_drive_top.f -----
rtl/core/hbd_pkg.sv
rtl/core/hbd_cmd_if.sv
rtl/core/hbd_drv_if.sv
rtl/core/hbd_poly_cell.sv
rtl/core/hbd_lane.sv
rtl/core/hbd_mix.sv
rtl/core/vector_to_hbridge_drive_top.sv
rtl/core/hbd_checker.sv
tb/tb_vector_to_hbridge_drive_top.sv
